/* hw/rtl/osa_pkg.sv */
// Shared constants, codes and control types of the free slot allocator.
`default_nettype none

package osa_pkg;

  // Table geometry.
  localparam int MAX_BLOCKS      = 16;
  localparam int SLOTS_PER_BLOCK = 1020;
  localparam int HINT_MULT       = 13;

  // Field widths of the channels and the configuration register.
  localparam int CFG_W    = 5;
  localparam int ID_W     = 32;
  localparam int HINT_W   = 8;
  localparam int IDX_W    = 14;
  localparam int STATUS_W = 2;

  // Occupancy bitmap: one bit per slot, packed into 32-bit rows.
  localparam int WORD_W         = 32;
  localparam int BIT_W          = $clog2(WORD_W);
  localparam int BLK_W          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NB_W           = $clog2(MAX_BLOCKS + 1);
  localparam int ROWS_PER_BLOCK = (SLOTS_PER_BLOCK + WORD_W - 1) / WORD_W;
  localparam int ROW_W          = (ROWS_PER_BLOCK > 1) ? $clog2(ROWS_PER_BLOCK) : 1;
  localparam int ROWCNT_W       = $clog2(ROWS_PER_BLOCK + 1);
  localparam int MEM_AW         = BLK_W + ROW_W;
  localparam int MEM_DEPTH      = MAX_BLOCKS * (1 << ROW_W);
  localparam int OFF_W          = ROW_W + BIT_W;
  localparam int LAST_BITS      = SLOTS_PER_BLOCK - (ROWS_PER_BLOCK - 1) * WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((64'd1 << LAST_BITS) - 64'd1);

  // Free count per block.
  localparam int FREE_W = $clog2(SLOTS_PER_BLOCK + 1);

  // Starting block: product of hint and multiplier, reduced bit by bit.
  localparam int HP_W    = $clog2(((1 << HINT_W) - 1) * HINT_MULT + 1);
  localparam int HSTEP_W = (HP_W > 1) ? $clog2(HP_W) : 1;

  // Split of a flat index by reciprocal multiplication plus one correction.
  localparam int DIV_SHIFT  = IDX_W + 1;
  localparam int DIV_MULT   = (1 << DIV_SHIFT) / SLOTS_PER_BLOCK;
  localparam int DIV_MULT_W = $clog2(DIV_MULT + 1);
  localparam int PROD_W     = IDX_W + DIV_MULT_W;
  localparam int QM_W       = IDX_W + FREE_W;

  // Width of block * slots + offset before it is cut to the index width.
  localparam int GF_W = BLK_W + FREE_W + 1;

  // Input kind code.
  localparam logic KIND_DEL = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_WALK,
    S_SCAN,
    S_ADD_UPD,
    S_DEL_MUL,
    S_DEL_Q,
    S_DEL_FIX,
    S_DEL_RD,
    S_DEL_UPD,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    clr_step;
    logic    mod_step;
    logic    walk_step;
    logic    scan_rd;
    logic    add_upd;
    logic    del_mul;
    logic    del_q;
    logic    del_fix;
    logic    del_rd;
    logic    del_upd;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic in_del;
    logic n_zero;
    logic mod_last;
    logic cnt_nz;
    logic walk_last;
    logic scan_hit;
    logic scan_end;
    logic del_bad;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/osa_in_if.sv */
// Input channel of the allocator: valid/ready handshake and the request word.
`default_nettype none

interface osa_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [osa_pkg::ID_W-1:0]   item_id;
  logic [osa_pkg::HINT_W-1:0] start_hint;
  logic [osa_pkg::IDX_W-1:0]  slot_index;

  modport source (output valid, output kind, output item_id, output start_hint,
                  output slot_index, input ready);
  modport sink   (input valid, input kind, input item_id, input start_hint,
                  input slot_index, output ready);
endinterface

`default_nettype wire

/* hw/rtl/osa_out_if.sv */
// Result channel of the allocator: valid/ready handshake and the result word.
`default_nettype none

interface osa_out_if;
  logic                         valid;
  logic                         ready;
  logic [osa_pkg::STATUS_W-1:0] status;
  logic [osa_pkg::IDX_W-1:0]    granted_index;
  logic                         table_empty;

  modport source (output valid, output status, output granted_index,
                  output table_empty, input ready);
  modport sink   (input valid, input status, input granted_index,
                  input table_empty, output ready);
endinterface

`default_nettype wire

/* hw/rtl/osa_ctrl.sv */
// Controller state machine of the allocator: sequences add, delete and clearing.
`default_nettype none

module osa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  osa_pkg::stat_t stat,
  output osa_pkg::cmd_t  cmd
);

  osa_pkg::state_t state_r;
  osa_pkg::state_t state_nxt;

  // State register; reset starts the bitmap clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= osa_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      osa_pkg::S_CLEAR: begin
        if (stat.clr_last) state_nxt = osa_pkg::S_IDLE;
      end
      osa_pkg::S_IDLE: begin
        if (in_valid) begin
          if (stat.in_del) begin
            state_nxt = osa_pkg::S_DEL_MUL;
          end else if (stat.n_zero) begin
            state_nxt = osa_pkg::S_DONE;
          end else begin
            state_nxt = osa_pkg::S_MOD;
          end
        end
      end
      osa_pkg::S_MOD: begin
        if (stat.mod_last) state_nxt = osa_pkg::S_WALK;
      end
      osa_pkg::S_WALK: begin
        if (stat.cnt_nz) begin
          state_nxt = osa_pkg::S_SCAN;
        end else if (stat.walk_last) begin
          state_nxt = osa_pkg::S_DONE;
        end
      end
      osa_pkg::S_SCAN: begin
        if (stat.scan_hit) begin
          state_nxt = osa_pkg::S_ADD_UPD;
        end else if (stat.scan_end) begin
          state_nxt = osa_pkg::S_DONE;
        end
      end
      osa_pkg::S_ADD_UPD: state_nxt = osa_pkg::S_DONE;
      osa_pkg::S_DEL_MUL: state_nxt = osa_pkg::S_DEL_Q;
      osa_pkg::S_DEL_Q:   state_nxt = osa_pkg::S_DEL_FIX;
      osa_pkg::S_DEL_FIX: state_nxt = osa_pkg::S_DEL_RD;
      osa_pkg::S_DEL_RD: begin
        if (stat.del_bad) begin
          state_nxt = osa_pkg::S_DONE;
        end else begin
          state_nxt = osa_pkg::S_DEL_UPD;
        end
      end
      osa_pkg::S_DEL_UPD: state_nxt = osa_pkg::S_DONE;
      osa_pkg::S_DONE: begin
        if (stat.out_free) state_nxt = osa_pkg::S_IDLE;
      end
      default: state_nxt = osa_pkg::S_IDLE;
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      osa_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      osa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        // An add with no blocks open fails at once.
        if (in_valid && !stat.in_del && stat.n_zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = osa_pkg::ST_NO_SPACE;
        end
      end
      osa_pkg::S_MOD: cmd.mod_step = 1'b1;
      osa_pkg::S_WALK: begin
        if (!stat.cnt_nz) begin
          if (stat.walk_last) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = osa_pkg::ST_NO_SPACE;
          end else begin
            cmd.walk_step = 1'b1;
          end
        end
      end
      osa_pkg::S_SCAN: begin
        cmd.scan_rd = !stat.scan_hit;
        if (!stat.scan_hit && stat.scan_end) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = osa_pkg::ST_NO_SPACE;
        end
      end
      osa_pkg::S_ADD_UPD: cmd.add_upd = 1'b1;
      osa_pkg::S_DEL_MUL: cmd.del_mul = 1'b1;
      osa_pkg::S_DEL_Q:   cmd.del_q   = 1'b1;
      osa_pkg::S_DEL_FIX: cmd.del_fix = 1'b1;
      osa_pkg::S_DEL_RD: begin
        if (stat.del_bad) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = osa_pkg::ST_BAD_INDEX;
        end else begin
          cmd.del_rd = 1'b1;
        end
      end
      osa_pkg::S_DEL_UPD: cmd.del_upd  = 1'b1;
      osa_pkg::S_DONE:    cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/osa_dp.sv */
// Datapath of the allocator: occupancy bitmap, free counts, index arithmetic, result word.
`default_nettype none

module osa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  osa_pkg::cmd_t                cmd,
  output osa_pkg::stat_t               stat,
  input  logic                         cfg_we,
  input  logic [osa_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_kind,
  input  logic [osa_pkg::ID_W-1:0]     in_item_id,
  input  logic [osa_pkg::HINT_W-1:0]   in_start_hint,
  input  logic [osa_pkg::IDX_W-1:0]    in_slot_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [osa_pkg::STATUS_W-1:0] out_status,
  output logic [osa_pkg::IDX_W-1:0]    out_granted_index,
  output logic                         out_table_empty
);

  // Configuration and clamped block count.
  logic [osa_pkg::CFG_W-1:0]  blocks_cfg_r;
  logic [osa_pkg::NB_W-1:0]   n_w;

  // Latched request.
  logic                       id_nz_r;
  logic [osa_pkg::IDX_W-1:0]  idx_r;

  // Starting block reduction.
  logic [osa_pkg::HP_W-1:0]    hp_sh_r;
  logic [osa_pkg::NB_W-1:0]    rem_r;
  logic [osa_pkg::NB_W-1:0]    rem_nxt;
  logic [osa_pkg::NB_W:0]      rem_try;
  logic [osa_pkg::HSTEP_W-1:0] step_r;

  // Block walk.
  logic [osa_pkg::BLK_W-1:0] b_r;
  logic [osa_pkg::NB_W-1:0]  b_inc;
  logic [osa_pkg::NB_W-1:0]  walk_r;

  // Row scan.
  logic [osa_pkg::ROWCNT_W-1:0] row_cnt_r;
  logic                         rd_issue;
  logic                         rd_vld_r;
  logic [osa_pkg::ROW_W-1:0]    rd_row_r;
  logic [osa_pkg::WORD_W-1:0]   row_mask;
  logic [osa_pkg::WORD_W-1:0]   free_bits;
  logic [osa_pkg::BIT_W-1:0]    first_bit;
  logic [osa_pkg::WORD_W-1:0]   word_r;
  logic [osa_pkg::OFF_W-1:0]    off_r;
  logic [osa_pkg::WORD_W-1:0]   bit_onehot;
  logic                         del_bit_set;

  // Flat index split.
  logic [osa_pkg::PROD_W-1:0]  prod_r;
  logic [osa_pkg::IDX_W-1:0]   q_r;
  logic [osa_pkg::QM_W-1:0]    qm_w;
  logic [osa_pkg::FREE_W:0]    fix_rem;
  logic [osa_pkg::IDX_W-1:0]   q_fix;
  logic [osa_pkg::FREE_W:0]    off_fix;

  // Bitmap memory.
  logic [osa_pkg::WORD_W-1:0] mem [osa_pkg::MEM_DEPTH];
  logic [osa_pkg::WORD_W-1:0] mem_q_r;
  logic                       mem_we;
  logic [osa_pkg::MEM_AW-1:0] mem_waddr;
  logic [osa_pkg::WORD_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [osa_pkg::MEM_AW-1:0] mem_raddr;
  logic [osa_pkg::MEM_AW-1:0] clr_r;

  // Free counts and result.
  logic [osa_pkg::FREE_W-1:0]   free_r [osa_pkg::MAX_BLOCKS];
  logic                         add_wr;
  logic [osa_pkg::GF_W-1:0]     grant_full;
  logic                         empty_w;
  osa_pkg::status_t             res_status_r;
  logic [osa_pkg::IDX_W-1:0]    res_grant_r;
  logic                         out_valid_r;
  logic [osa_pkg::STATUS_W-1:0] out_status_r;
  logic [osa_pkg::IDX_W-1:0]    out_grant_r;
  logic                         out_empty_r;

  // Block count, clamped to the table size.
  always_comb begin
    if (int'(blocks_cfg_r) > osa_pkg::MAX_BLOCKS) begin
      n_w = osa_pkg::NB_W'(osa_pkg::MAX_BLOCKS);
    end else begin
      n_w = osa_pkg::NB_W'(blocks_cfg_r);
    end
  end

  // One restoring step of (hint * multiplier) mod block count.
  always_comb begin
    rem_try = {rem_r, hp_sh_r[osa_pkg::HP_W-1]};
    if (rem_try >= {1'b0, n_w}) begin
      rem_nxt = osa_pkg::NB_W'(rem_try - {1'b0, n_w});
    end else begin
      rem_nxt = osa_pkg::NB_W'(rem_try);
    end
  end

  assign b_inc = osa_pkg::NB_W'(b_r) + 1'b1;

  // Scan reads stop once every row of the block has been issued.
  assign rd_issue = cmd.scan_rd &&
                    (row_cnt_r != osa_pkg::ROWCNT_W'(osa_pkg::ROWS_PER_BLOCK));

  // Slots past the end of the block count as taken.
  assign row_mask  = (rd_row_r == osa_pkg::ROW_W'(osa_pkg::ROWS_PER_BLOCK - 1)) ?
                     osa_pkg::LAST_MASK : '1;
  assign free_bits = ~mem_q_r & row_mask;

  // Lowest empty slot of the row just read.
  always_comb begin
    first_bit = '0;
    for (int i = osa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) first_bit = osa_pkg::BIT_W'(i);
    end
  end

  assign bit_onehot  = osa_pkg::WORD_W'(1) << off_r[osa_pkg::BIT_W-1:0];
  assign del_bit_set = mem_q_r[off_r[osa_pkg::BIT_W-1:0]];

  // Correction of the reciprocal estimate of index / slots per block.
  always_comb begin
    qm_w    = osa_pkg::QM_W'(q_r) * osa_pkg::QM_W'(osa_pkg::SLOTS_PER_BLOCK);
    fix_rem = (osa_pkg::FREE_W + 1)'(osa_pkg::QM_W'(idx_r) - qm_w);
    if (fix_rem >= (osa_pkg::FREE_W + 1)'(osa_pkg::SLOTS_PER_BLOCK)) begin
      q_fix   = q_r + 1'b1;
      off_fix = fix_rem - (osa_pkg::FREE_W + 1)'(osa_pkg::SLOTS_PER_BLOCK);
    end else begin
      q_fix   = q_r;
      off_fix = fix_rem;
    end
  end

  // Flat index of the slot being granted.
  assign grant_full = osa_pkg::GF_W'(b_r) * osa_pkg::GF_W'(osa_pkg::SLOTS_PER_BLOCK) +
                      osa_pkg::GF_W'(off_r);

  // Table is empty when every open block has all of its slots free.
  always_comb begin
    empty_w = 1'b1;
    for (int b = 0; b < osa_pkg::MAX_BLOCKS; b++) begin
      if (b < int'(n_w) && free_r[b] != osa_pkg::FREE_W'(osa_pkg::SLOTS_PER_BLOCK)) begin
        empty_w = 1'b0;
      end
    end
  end

  // Bitmap port selection.
  assign add_wr = cmd.add_upd && id_nz_r;
  always_comb begin
    mem_we    = cmd.clr_step || add_wr || (cmd.del_upd && del_bit_set);
    mem_waddr = {b_r, off_r[osa_pkg::OFF_W-1:osa_pkg::BIT_W]};
    mem_wdata = mem_q_r & ~bit_onehot;
    if (cmd.clr_step) begin
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (cmd.add_upd) begin
      mem_wdata = word_r | bit_onehot;
    end
    mem_re    = rd_issue || cmd.del_rd;
    mem_raddr = rd_issue ? {b_r, row_cnt_r[osa_pkg::ROW_W-1:0]}
                         : {b_r, off_r[osa_pkg::OFF_W-1:osa_pkg::BIT_W]};
  end

  // Bitmap memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q_r <= mem[mem_raddr];
  end

  // Control registers: configuration, free counts, sweep and handshake state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_cfg_r <= '0;
      clr_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int b = 0; b < osa_pkg::MAX_BLOCKS; b++) begin
        free_r[b] <= osa_pkg::FREE_W'(osa_pkg::SLOTS_PER_BLOCK);
      end
    end else begin
      if (cfg_we) blocks_cfg_r <= cfg_wdata;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      rd_vld_r <= rd_issue;
      if (add_wr) begin
        free_r[b_r] <= free_r[b_r] - 1'b1;
      end else if (cmd.del_upd && del_bit_set) begin
        free_r[b_r] <= free_r[b_r] + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_nz_r   <= |in_item_id;
      idx_r     <= in_slot_index;
      hp_sh_r   <= osa_pkg::HP_W'(in_start_hint) * osa_pkg::HP_W'(osa_pkg::HINT_MULT);
      rem_r     <= '0;
      step_r    <= '0;
      row_cnt_r <= '0;
    end
    if (cmd.mod_step) begin
      hp_sh_r <= hp_sh_r << 1;
      step_r  <= step_r + 1'b1;
      rem_r   <= rem_nxt;
      if (stat.mod_last) begin
        b_r    <= osa_pkg::BLK_W'(rem_nxt);
        walk_r <= '0;
      end
    end
    if (cmd.walk_step) begin
      b_r    <= (b_inc == n_w) ? '0 : osa_pkg::BLK_W'(b_inc);
      walk_r <= walk_r + 1'b1;
    end
    if (rd_issue) row_cnt_r <= row_cnt_r + 1'b1;
    rd_row_r <= row_cnt_r[osa_pkg::ROW_W-1:0];
    // Keep the row and position of the first empty slot found.
    if (stat.scan_hit) begin
      word_r <= mem_q_r;
      off_r  <= {rd_row_r, first_bit};
    end
    if (cmd.del_mul) prod_r <= osa_pkg::PROD_W'(idx_r) * osa_pkg::PROD_W'(osa_pkg::DIV_MULT);
    if (cmd.del_q) q_r <= osa_pkg::IDX_W'(prod_r >> osa_pkg::DIV_SHIFT);
    if (cmd.del_fix) begin
      q_r   <= q_fix;
      b_r   <= osa_pkg::BLK_W'(q_fix);
      off_r <= osa_pkg::OFF_W'(off_fix);
    end
  end

  // Result word under construction and the output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= osa_pkg::ST_OK;
      res_grant_r  <= '0;
    end
    if (cmd.res_set) res_status_r <= cmd.res_code;
    if (cmd.add_upd) res_grant_r <= osa_pkg::IDX_W'(grant_full);
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_grant_r  <= res_grant_r;
      out_empty_r  <= empty_w;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.clr_last  = (clr_r == osa_pkg::MEM_AW'(osa_pkg::MEM_DEPTH - 1));
    stat.in_del    = (in_kind == osa_pkg::KIND_DEL);
    stat.n_zero    = (n_w == '0);
    stat.mod_last  = (step_r == osa_pkg::HSTEP_W'(osa_pkg::HP_W - 1));
    stat.cnt_nz    = (free_r[b_r] != '0);
    stat.walk_last = (osa_pkg::NB_W'(walk_r + 1'b1) == n_w);
    stat.scan_hit  = rd_vld_r && (|free_bits);
    stat.scan_end  = rd_vld_r &&
                     (rd_row_r == osa_pkg::ROW_W'(osa_pkg::ROWS_PER_BLOCK - 1));
    stat.del_bad   = (q_r >= osa_pkg::IDX_W'(n_w));
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_grant_r;
  assign out_table_empty   = out_empty_r;

endmodule

`default_nettype wire

/* hw/rtl/orphan_slot_allocator.sv */
// Add: reduce the hint, walk w blocks, scan to row r of the hit; one word in flight at a time.
// Add time is set by the 12-step hint reduction, the one-block-a-cycle walk and the row scan.
// Delete: multiply, quotient, fix, read, update (none for an index outside the open blocks).
// A new word is taken while the previous result still waits in the output register.
// After reset the slot bitmap is cleared one row a cycle over all 512 rows; no word is taken.
// Reset sets the block count to 0 and every free count to the full block size.
`default_nettype none

module orphan_slot_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  osa_in_if.sink                    in_ch,
  osa_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [osa_pkg::CFG_W-1:0] cfg_wdata
);

  osa_pkg::cmd_t  cmd;
  osa_pkg::stat_t stat;

  // Sequencer.
  osa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  osa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_ch.kind),
    .in_item_id        (in_ch.item_id),
    .in_start_hint     (in_ch.start_hint),
    .in_slot_index     (in_ch.slot_index),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_granted_index (out_ch.granted_index),
    .out_table_empty   (out_ch.table_empty)
  );

endmodule

`default_nettype wire
